FILE: src/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg - shared types and constants of the CAN signal decoder
// Field widths, command and result records, and the signal table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

  localparam int SIGNAL_SLOTS_DEF = 16;
  localparam int SLOT_PORT_W      = 4;
  localparam int ID_W             = 29;
  localparam int DATA_W           = 64;
  localparam int POS_W            = 6;
  localparam int RAW_W            = 32;
  localparam int SCALE_W          = 32;
  localparam int OFF_W            = 48;
  localparam int VAL_W            = 64;
  localparam int CMD_DEPTH        = 2;
  localparam int RES_DEPTH        = 2;

  localparam logic [POS_W-1:0] LEN_MAX = 6'd32;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // One queued command, either a table load or a frame decode
  typedef struct packed {
    logic                   func;
    logic [SLOT_PORT_W-1:0] slot;
    logic [ID_W-1:0]        msg_id;
    logic [POS_W-1:0]       start;
    logic [POS_W-1:0]       len;
    logic [SCALE_W-1:0]     scale;
    logic [OFF_W-1:0]       offset;
    logic                   enable;
    logic [ID_W-1:0]        frame_id;
    logic [DATA_W-1:0]      frame_data;
  } cmd_t;

  // Per-slot signal definition held in the table memory
  typedef struct packed {
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   len;
    logic [SCALE_W-1:0] scale;
    logic [OFF_W-1:0]   offset;
  } ent_t;

  typedef struct packed {
    logic                   matched;
    logic [SLOT_PORT_W-1:0] slot;
    logic [VAL_W-1:0]       value;
    logic                   saturated;
    logic                   last;
  } res_t;

endpackage

`default_nettype wire

FILE: src/csd_ram.sv
// ----------------------------------------------------------------------------
// csd_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: src/csd_fifo.sv
// ----------------------------------------------------------------------------
// csd_fifo - small flop-based queue
// Parts producer and consumer so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/csd_front.sv
// ----------------------------------------------------------------------------
// csd_front - input classification for the CAN signal decoder
// Sorts items into loads and decodes, drops loads aimed past the table and
// clamps signal lengths before queueing the command.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_front #(
  parameter int SIGNAL_SLOTS = csd_pkg::SIGNAL_SLOTS_DEF
) (
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                in_func,
  input  wire logic        [csd_pkg::SLOT_PORT_W-1:0] in_entry_slot,
  input  wire logic        [csd_pkg::ID_W-1:0]     in_entry_msg_id,
  input  wire logic        [csd_pkg::POS_W-1:0]    in_entry_start_bit,
  input  wire logic        [csd_pkg::POS_W-1:0]    in_entry_length,
  input  wire logic signed [csd_pkg::SCALE_W-1:0]  in_entry_scale,
  input  wire logic signed [csd_pkg::OFF_W-1:0]    in_entry_offset,
  input  wire logic                                in_entry_enable,
  input  wire logic        [csd_pkg::ID_W-1:0]     in_frame_id,
  input  wire logic        [csd_pkg::DATA_W-1:0]   in_frame_data,
  output logic                                     cmd_push,
  output csd_pkg::cmd_t                            cmd,
  input  wire logic                                cmd_full
);

  logic keep;

  // Loads beyond the table have no effect, so never queue them
  assign keep = (in_func == csd_pkg::FUNC_DECODE) ||
                ({28'd0, in_entry_slot} < 32'(SIGNAL_SLOTS));

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && keep;

  always_comb begin
    cmd.func       = in_func;
    cmd.slot       = in_entry_slot;
    cmd.msg_id     = in_entry_msg_id;
    cmd.start      = in_entry_start_bit;
    cmd.len        = (in_entry_length > csd_pkg::LEN_MAX) ? csd_pkg::LEN_MAX
                                                          : in_entry_length;
    cmd.scale      = in_entry_scale;
    cmd.offset     = in_entry_offset;
    cmd.enable     = in_entry_enable;
    cmd.frame_id   = in_frame_id;
    cmd.frame_data = in_frame_data;
  end

endmodule

`default_nettype wire

FILE: src/csd_back.sv
// ----------------------------------------------------------------------------
// csd_back - table keeper and slot sequencer of the CAN signal decoder
// Applies loads to the signal table and walks the slots for each decode,
// extracting, scaling and offsetting every matching signal.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_back #(
  parameter int SIGNAL_SLOTS = csd_pkg::SIGNAL_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire csd_pkg::cmd_t cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  output logic               res_push,
  output csd_pkg::res_t      res,
  input  wire logic          res_full
);

  localparam int SLOT_W = (SIGNAL_SLOTS > 1) ? $clog2(SIGNAL_SLOTS) : 1;
  localparam int SP_W   = csd_pkg::SLOT_PORT_W;
  localparam int ENT_W  = $bits(csd_pkg::ent_t);
  localparam int SUM_W  = csd_pkg::VAL_W + 1;
  localparam int OFF_X  = SUM_W - csd_pkg::OFF_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_EXT     = 3'd2;
  localparam logic [2:0] ST_MUL     = 3'd3;
  localparam logic [2:0] ST_ADD     = 3'd4;
  localparam logic [2:0] ST_NOMATCH = 3'd5;

  logic [2:0]                        state_r;
  logic [2:0]                        state_nxt;
  logic [SLOT_W-1:0]                 idx_r;
  logic [SIGNAL_SLOTS-1:0]           remain_r;
  logic [SIGNAL_SLOTS-1:0]           remain_clr;
  logic [SIGNAL_SLOTS-1:0]           match;
  logic [SIGNAL_SLOTS-1:0]           en_r;
  logic [csd_pkg::ID_W-1:0]          msg_id_r [SIGNAL_SLOTS];
  logic [csd_pkg::DATA_W-1:0]        data_r;
  logic [csd_pkg::RAW_W-1:0]         raw_r;
  logic signed [csd_pkg::SCALE_W-1:0] scale_r;
  logic [csd_pkg::OFF_W-1:0]         off_r;
  logic [csd_pkg::VAL_W-1:0]         prod_r;

  logic                              ram_we;
  logic [SLOT_W-1:0]                 ld_slot;
  csd_pkg::ent_t                     ent_w;
  logic [ENT_W-1:0]                  ent_rdata;
  csd_pkg::ent_t                     ent;

  logic [csd_pkg::DATA_W-1:0]        shifted;
  logic [csd_pkg::RAW_W:0]           mask;
  logic signed [csd_pkg::RAW_W:0]    raw_s;
  logic signed [SUM_W-1:0]           prod_full;
  logic [SUM_W-1:0]                  sum;
  logic                              ovf;
  logic [csd_pkg::VAL_W-1:0]         val;

  assign ld_slot = SLOT_W'(cmd.slot);

  always_comb begin
    ent_w.start  = cmd.start;
    ent_w.len    = cmd.len;
    ent_w.scale  = cmd.scale;
    ent_w.offset = cmd.offset;
  end

  csd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SIGNAL_SLOTS),
    .AW    (SLOT_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ld_slot),
    .wdata (ent_w),
    .raddr (idx_r),
    .rdata (ent_rdata)
  );

  assign ent = ent_rdata;

  always_comb begin
    for (int i = 0; i < SIGNAL_SLOTS; i++) begin
      match[i] = en_r[i] && (msg_id_r[i] == cmd.frame_id);
    end
  end

  always_comb begin
    remain_clr         = remain_r;
    remain_clr[idx_r]  = 1'b0;
  end

  // Field extraction, little-endian bit numbering
  assign shifted = data_r >> ent.start;
  assign mask    = (33'h1 << ent.len) - 33'h1;

  assign raw_s     = signed'({1'b0, raw_r});
  assign prod_full = raw_s * scale_r;

  // Add offset with one guard bit and clip on overflow
  assign sum = {prod_r[csd_pkg::VAL_W-1], prod_r} + {{OFF_X{off_r[csd_pkg::OFF_W-1]}}, off_r};
  assign ovf = sum[SUM_W-1] ^ sum[SUM_W-2];
  assign val = ovf ? (sum[SUM_W-1] ? csd_pkg::VAL_MIN : csd_pkg::VAL_MAX)
                   : sum[csd_pkg::VAL_W-1:0];

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    res_push  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.func == csd_pkg::FUNC_LOAD) begin
            ram_we = 1'b1;
          end else begin
            state_nxt = (|match) ? ST_SCAN : ST_NOMATCH;
          end
        end
      end
      ST_SCAN: begin
        if (remain_r[idx_r]) begin
          state_nxt = ST_EXT;
        end
      end
      ST_EXT: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = (|remain_clr) ? ST_SCAN : ST_IDLE;
        end
      end
      ST_NOMATCH: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res.matched   = (state_r == ST_ADD);
    res.slot      = (state_r == ST_ADD) ? SP_W'(idx_r) : '0;
    res.value     = (state_r == ST_ADD) ? val : '0;
    res.saturated = (state_r == ST_ADD) && ovf;
    res.last      = (state_r == ST_ADD) ? !(|remain_clr) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      remain_r <= '0;
      en_r     <= '0;
      for (int i = 0; i < SIGNAL_SLOTS; i++) begin
        msg_id_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (!cmd_empty) begin
            if (cmd.func == csd_pkg::FUNC_LOAD) begin
              msg_id_r[ld_slot] <= cmd.msg_id;
              en_r[ld_slot]     <= cmd.enable;
            end else begin
              remain_r <= match;
              idx_r    <= '0;
            end
          end
        end
        ST_SCAN: begin
          // Advance past slots that do not match
          if (!remain_r[idx_r]) begin
            idx_r <= idx_r + SLOT_W'(1);
          end
        end
        ST_ADD: begin
          if (!res_full) begin
            remain_r <= remain_clr;
            if (|remain_clr) begin
              idx_r <= idx_r + SLOT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && !cmd_empty && cmd.func == csd_pkg::FUNC_DECODE) begin
      data_r <= cmd.frame_data;
    end
    if (state_r == ST_EXT) begin
      raw_r   <= shifted[csd_pkg::RAW_W-1:0] & mask[csd_pkg::RAW_W-1:0];
      scale_r <= ent.scale;
      off_r   <= ent.offset;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_full[csd_pkg::VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/can_signal_decoder.sv
// ----------------------------------------------------------------------------
// can_signal_decoder - table-driven CAN signal decoder
// Holds signal definitions and turns each received frame into scaled values.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  input    | push / full      | in_func, in_entry_*, in_frame_id, in_frame_data
//  result   | empty / pop      | out_matched, out_signal_slot, out_value, out_saturated, out_last
//
//  A load is written to the table by the sequencer. A decode first matches the
//  frame id against every enabled slot, then walks the slots up to the highest
//  matching one, with field extract, multiply and offset add for each match.
//  Reset clears every slot enable and empties both queues.
//  A full result queue holds the sequencer; the input queue keeps taking
//  items until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module can_signal_decoder #(
  parameter int SIGNAL_SLOTS = csd_pkg::SIGNAL_SLOTS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic                                  in_func,
  input  wire logic        [csd_pkg::SLOT_PORT_W-1:0] in_entry_slot,
  input  wire logic        [csd_pkg::ID_W-1:0]       in_entry_msg_id,
  input  wire logic        [csd_pkg::POS_W-1:0]      in_entry_start_bit,
  input  wire logic        [csd_pkg::POS_W-1:0]      in_entry_length,
  input  wire logic signed [csd_pkg::SCALE_W-1:0]    in_entry_scale,
  input  wire logic signed [csd_pkg::OFF_W-1:0]      in_entry_offset,
  input  wire logic                                  in_entry_enable,
  input  wire logic        [csd_pkg::ID_W-1:0]       in_frame_id,
  input  wire logic        [csd_pkg::DATA_W-1:0]     in_frame_data,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic                                       out_matched,
  output logic             [csd_pkg::SLOT_PORT_W-1:0] out_signal_slot,
  output logic signed      [csd_pkg::VAL_W-1:0]      out_value,
  output logic                                       out_saturated,
  output logic                                       out_last
);

  localparam int CMD_W = $bits(csd_pkg::cmd_t);
  localparam int RES_W = $bits(csd_pkg::res_t);

  csd_pkg::cmd_t    cmd_in;
  csd_pkg::cmd_t    cmd_q;
  logic [CMD_W-1:0] cmd_dout;
  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_empty;

  csd_pkg::res_t    res_in;
  csd_pkg::res_t    res_q;
  logic [RES_W-1:0] res_dout;
  logic             res_push;
  logic             res_full;

  csd_front #(
    .SIGNAL_SLOTS (SIGNAL_SLOTS)
  ) u_front (
    .push               (push),
    .full               (full),
    .in_func            (in_func),
    .in_entry_slot      (in_entry_slot),
    .in_entry_msg_id    (in_entry_msg_id),
    .in_entry_start_bit (in_entry_start_bit),
    .in_entry_length    (in_entry_length),
    .in_entry_scale     (in_entry_scale),
    .in_entry_offset    (in_entry_offset),
    .in_entry_enable    (in_entry_enable),
    .in_frame_id        (in_frame_id),
    .in_frame_data      (in_frame_data),
    .cmd_push           (cmd_push),
    .cmd                (cmd_in),
    .cmd_full           (cmd_full)
  );

  csd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (csd_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  assign cmd_q = cmd_dout;

  csd_back #(
    .SIGNAL_SLOTS (SIGNAL_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_q),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  csd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (csd_pkg::RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign res_q           = res_dout;
  assign out_matched     = res_q.matched;
  assign out_signal_slot = res_q.slot;
  assign out_value       = res_q.value;
  assign out_saturated   = res_q.saturated;
  assign out_last        = res_q.last;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the CAN signal decoder
// Loads signal definitions, decodes frames against a shadow copy of the
// signal table, and checks every scaled value in order under random idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ID_W        = csd_pkg::ID_W;
  localparam int SLOT_PORT_W = csd_pkg::SLOT_PORT_W;
  localparam int POS_W       = csd_pkg::POS_W;
  localparam int SCALE_W     = csd_pkg::SCALE_W;
  localparam int OFF_W       = csd_pkg::OFF_W;
  localparam int DATA_W      = csd_pkg::DATA_W;
  localparam int VAL_W       = csd_pkg::VAL_W;

  localparam int NUM_SLOTS       = csd_pkg::SIGNAL_SLOTS_DEF;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int TAIL_CYCLES     = 100;
  localparam int RESET_CYCLES    = 12;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int POOL_SIZE       = 4;
  localparam int MAX_PRINTS      = 40;

  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
  localparam logic [ID_W-1:0] ID_A   = 29'h0ABC_DEF1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic push  = 1'b0;
  logic pop   = 1'b0;
  logic full;
  logic empty;
  csd_pkg::cmd_t drv_cmd = '0;

  logic                   out_matched;
  logic [SLOT_PORT_W-1:0] out_signal_slot;
  logic [VAL_W-1:0]       out_value;
  logic                   out_saturated;
  logic                   out_last;

  // stimulus and checking state
  csd_pkg::cmd_t pending_cmds[$];
  csd_pkg::res_t expected_values[$];
  logic sent_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   items_queued = 0;
  int   cycle_count = 0;
  int   error_count = 0;
  int   loads_sent = 0;
  int   decodes_sent = 0;
  int   values_checked = 0;
  int   saturations_seen = 0;
  int   misses_seen = 0;
  logic [ID_W-1:0] pool_ids [POOL_SIZE];

  // shadow signal table
  logic [ID_W-1:0]    tbl_msg_id [NUM_SLOTS];
  logic               tbl_enable [NUM_SLOTS];
  logic [POS_W-1:0]   tbl_start  [NUM_SLOTS];
  logic [POS_W-1:0]   tbl_len    [NUM_SLOTS];
  logic [SCALE_W-1:0] tbl_scale  [NUM_SLOTS];
  logic [OFF_W-1:0]   tbl_offset [NUM_SLOTS];

  can_signal_decoder i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_func            (drv_cmd.func),
    .in_entry_slot      (drv_cmd.slot),
    .in_entry_msg_id    (drv_cmd.msg_id),
    .in_entry_start_bit (drv_cmd.start),
    .in_entry_length    (drv_cmd.len),
    .in_entry_scale     (drv_cmd.scale),
    .in_entry_offset    (drv_cmd.offset),
    .in_entry_enable    (drv_cmd.enable),
    .in_frame_id        (drv_cmd.frame_id),
    .in_frame_data      (drv_cmd.frame_data),
    .empty              (empty),
    .pop                (pop),
    .out_matched        (out_matched),
    .out_signal_slot    (out_signal_slot),
    .out_value          (out_value),
    .out_saturated      (out_saturated),
    .out_last           (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    // hold the log short when the block is badly off
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic void table_load(csd_pkg::cmd_t c);
    if (c.slot < NUM_SLOTS) begin
      tbl_msg_id[c.slot] = c.msg_id;
      tbl_enable[c.slot] = c.enable;
      tbl_start[c.slot]  = c.start;
      tbl_len[c.slot]    = c.len;
      tbl_scale[c.slot]  = c.scale;
      tbl_offset[c.slot] = c.offset;
    end
  endfunction

  // Walk the table in slot order and queue one scaled value per matching slot
  function automatic void frame_decode(csd_pkg::cmd_t c);
    csd_pkg::res_t           hits [NUM_SLOTS];
    csd_pkg::res_t           r;
    int                      n_hits;
    int                      s;
    int                      width;
    logic [DATA_W-1:0]       field;
    logic signed [VAL_W-1:0] raw_s;
    logic signed [VAL_W-1:0] scale_s;
    logic signed [VAL_W-1:0] prod;
    logic [VAL_W:0]          sum;
    n_hits = 0;
    for (s = 0; s < NUM_SLOTS; s++) begin
      if (tbl_enable[s] && tbl_msg_id[s] == c.frame_id) begin
        width = (tbl_len[s] > csd_pkg::LEN_MAX) ? int'(csd_pkg::LEN_MAX)
                                                : int'(tbl_len[s]);
        // bits shifted in from past bit 63 are zero
        field = c.frame_data >> tbl_start[s];
        if (width == 0) begin
          field = '0;
        end else begin
          field = field & ((64'd1 << width) - 64'd1);
        end
        raw_s   = field;
        scale_s = {{(VAL_W-SCALE_W){tbl_scale[s][SCALE_W-1]}}, tbl_scale[s]};
        prod    = raw_s * scale_s;
        sum     = {prod[VAL_W-1], prod}
                + {{(VAL_W+1-OFF_W){tbl_offset[s][OFF_W-1]}}, tbl_offset[s]};
        r.matched = 1'b1;
        r.slot    = SLOT_PORT_W'(s);
        r.last    = 1'b0;
        if (sum[VAL_W] != sum[VAL_W-1]) begin
          r.value     = sum[VAL_W] ? csd_pkg::VAL_MIN : csd_pkg::VAL_MAX;
          r.saturated = 1'b1;
        end else begin
          r.value     = sum[VAL_W-1:0];
          r.saturated = 1'b0;
        end
        hits[n_hits] = r;
        n_hits++;
      end
    end
    if (n_hits == 0) begin
      r      = '0;
      r.last = 1'b1;
      expected_values.push_back(r);
    end else begin
      hits[n_hits-1].last = 1'b1;
      for (s = 0; s < n_hits; s++) begin
        expected_values.push_back(hits[s]);
      end
    end
  endfunction

  function automatic csd_pkg::cmd_t load_cmd(logic [SLOT_PORT_W-1:0] slot,
                                             logic [ID_W-1:0] id,
                                             logic [POS_W-1:0] start,
                                             logic [POS_W-1:0] len,
                                             logic [SCALE_W-1:0] scale,
                                             logic [OFF_W-1:0] offset,
                                             logic en);
    csd_pkg::cmd_t c;
    c.func       = csd_pkg::FUNC_LOAD;
    c.slot       = slot;
    c.msg_id     = id;
    c.start      = start;
    c.len        = len;
    c.scale      = scale;
    c.offset     = offset;
    c.enable     = en;
    c.frame_id   = ID_W'($urandom);
    c.frame_data = {$urandom, $urandom};
    return c;
  endfunction

  function automatic csd_pkg::cmd_t decode_cmd(logic [ID_W-1:0] id,
                                               logic [DATA_W-1:0] data);
    csd_pkg::cmd_t c;
    c            = load_cmd(SLOT_PORT_W'($urandom), ID_W'($urandom), POS_W'($urandom),
                            POS_W'($urandom), $urandom, OFF_W'({$urandom, $urandom}),
                            1'($urandom));
    c.func       = csd_pkg::FUNC_DECODE;
    c.frame_id   = id;
    c.frame_data = data;
    return c;
  endfunction

  function automatic logic [POS_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 14) return POS_W'($urandom_range(33, 63));
    return POS_W'($urandom_range(1, 32));
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 32'h7FFF_FFFF;
    if (r < 30) return 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [OFF_W-1:0] pick_offset();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 48'h7FFF_FFFF_FFFF;
    if (r < 20) return 48'h8000_0000_0000;
    return OFF_W'({$urandom, $urandom});
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '1;
    if (r < 20) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic csd_pkg::cmd_t random_load(logic [SLOT_PORT_W-1:0] slot,
                                                logic [ID_W-1:0] id, logic en);
    return load_cmd(slot, id, POS_W'($urandom_range(63)), pick_length(), pick_scale(),
                    pick_offset(), en);
  endfunction

  function automatic void enqueue(csd_pkg::cmd_t c);
    pending_cmds.push_back(c);
    items_queued++;
  endfunction

  // Mostly load-then-decode sequences on a small id pool, plus noise
  task automatic queue_random_traffic(int n_items);
    int              goal;
    int              kind;
    int              k;
    logic [ID_W-1:0] id;
    goal = items_queued + n_items;
    while (items_queued < goal) begin
      kind = $urandom_range(99);
      id   = pool_ids[$urandom_range(POOL_SIZE-1)];
      if (kind < 60) begin
        repeat ($urandom_range(1, 4)) begin
          enqueue(random_load(SLOT_PORT_W'($urandom), id, $urandom_range(7) != 0));
        end
        repeat ($urandom_range(1, 3)) enqueue(decode_cmd(id, pick_data()));
      end else if (kind < 70) begin
        for (k = 0; k < NUM_SLOTS; k++) begin
          enqueue(random_load(SLOT_PORT_W'(k), id, $urandom_range(7) != 0));
        end
        enqueue(decode_cmd(id, pick_data()));
      end else if (kind < 85) begin
        enqueue(decode_cmd(ID_W'($urandom), pick_data()));
      end else if (kind < 93) begin
        enqueue(random_load(SLOT_PORT_W'($urandom), ID_W'($urandom), 1'($urandom)));
      end else begin
        // drop a slot, then try a near-miss id and the real one
        enqueue(random_load(SLOT_PORT_W'($urandom), id, 1'b0));
        enqueue(decode_cmd(id ^ (ID_W'(1) << $urandom_range(ID_W-1)), pick_data()));
        enqueue(decode_cmd(id, pick_data()));
      end
    end
  endtask

  task automatic wait_sent();
    while (pending_cmds.size() != 0 || push) @(posedge clk);
  endtask

  task automatic drain();
    wait_sent();
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  // Input side: advance to the next pending item once the current one transfers
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (!push || sent_taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_cmd <= pending_cmds.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    csd_pkg::res_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("result from slot %0d with nothing expected",
                                    out_signal_slot));
        end else begin
          want = expected_values.pop_front();
          values_checked++;
          if (want.saturated) saturations_seen++;
          if (!want.matched) misses_seen++;
          if (out_matched !== want.matched) begin
            report_mismatch($sformatf("matched %b, want %b", out_matched, want.matched));
          end
          if (out_signal_slot !== want.slot) begin
            report_mismatch($sformatf("slot %0d, want %0d", out_signal_slot, want.slot));
          end
          if (out_value !== want.value) begin
            report_mismatch($sformatf("slot %0d value %h, want %h", want.slot, out_value,
                                      want.value));
          end
          if (out_saturated !== want.saturated) begin
            report_mismatch($sformatf("slot %0d saturated %b, want %b", want.slot,
                                      out_saturated, want.saturated));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("slot %0d last %b, want %b", want.slot, out_last,
                                      want.last));
          end
        end
      end
      sent_taken = push && !full;
      if (sent_taken) begin
        if (drv_cmd.func == csd_pkg::FUNC_LOAD) begin
          table_load(drv_cmd);
          loads_sent++;
        end else begin
          frame_decode(drv_cmd);
          decodes_sent++;
        end
      end
    end else begin
      sent_taken = 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_values.size());
      $display("FAIL can_signal_decoder");
      $finish;
    end
  end

  initial begin
    int s;
    int ph;
    for (s = 0; s < NUM_SLOTS; s++) begin
      tbl_msg_id[s] = '0;
      tbl_enable[s] = 1'b0;
      tbl_start[s]  = '0;
      tbl_len[s]    = '0;
      tbl_scale[s]  = '0;
      tbl_offset[s] = '0;
    end
    for (s = 0; s < POOL_SIZE; s++) pool_ids[s] = ID_W'($urandom);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes of every field, saturation both ways
    enqueue(decode_cmd('0, '1));
    enqueue(load_cmd(4'd0, ID_A, 6'd0, 6'd32, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b1));
    enqueue(load_cmd(4'd15, ID_A, 6'd32, 6'd32, 32'h8000_0000, 48'h8000_0000_0000, 1'b1));
    enqueue(load_cmd(4'd7, ID_A, 6'd60, 6'd8, 32'h0001_0000, '0, 1'b1));
    enqueue(load_cmd(4'd3, ID_A, 6'd5, 6'd0, 32'h1234_5678, 48'hFFFF_FFFF_CFC7, 1'b1));
    enqueue(load_cmd(4'd9, ID_A, 6'd0, 6'd63, 32'hFFFF_FFFF, 48'h0000_0001_0000, 1'b1));
    enqueue(load_cmd(4'd5, ID_A, 6'd8, 6'd16, 32'h0002_0000, '0, 1'b0));
    enqueue(decode_cmd(ID_A, '1));
    enqueue(decode_cmd(ID_A, '0));
    enqueue(decode_cmd(ID_A, 64'h0123_4567_89AB_CDEF));
    enqueue(decode_cmd(ID_MAX, '1));
    enqueue(load_cmd(4'd1, ID_MAX, 6'd63, 6'd1, 32'h0000_0001, '0, 1'b1));
    enqueue(load_cmd(4'd2, '0, 6'd31, 6'd33, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b1));
    enqueue(decode_cmd(ID_MAX, 64'h8000_0000_0000_0000));
    enqueue(decode_cmd('0, 64'hFFFF_FFFF_8000_0000));
    enqueue(load_cmd(4'd0, ID_A, 6'd0, 6'd32, 32'h7FFF_FFFF, '0, 1'b0));
    enqueue(decode_cmd(ID_A, '1));
    enqueue(load_cmd(4'd15, ID_A, 6'd32, 6'd32, 32'h8000_0000, 48'h7FFF_FFFF_FFFF, 1'b1));
    enqueue(decode_cmd(ID_A, '1));

    // hold the sender until every queued value has come back
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      queue_random_traffic(ITEMS_PER_PHASE);
      wait_sent();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_values.size() != 0) begin
      report_mismatch($sformatf("%0d values never arrived", expected_values.size()));
    end

    $display("covered %0d table loads and %0d frame decodes, %0d values checked",
             loads_sent, decodes_sent, values_checked);
    $display("%0d saturated values, %0d frames without a matching signal, %0d errors",
             saturations_seen, misses_seen, error_count);
    if (error_count == 0) begin
      $display("PASS can_signal_decoder");
    end else begin
      $display("FAIL can_signal_decoder");
    end
    $finish;
  end

endmodule
